// ===== rtl/wtcp_pkg.sv =====
package wtcp_pkg;

    // Sizes of the command format.
    localparam int LINE_MAX   = 48;
    localparam int WHEELS     = 4;
    localparam int MAX_DIGITS = 7;

    localparam int LEN_W   = $clog2(LINE_MAX);
    localparam int WHEEL_W = $clog2(WHEELS);
    localparam int VCNT_W  = $clog2(WHEELS + 1);
    localparam int DCNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int ACC_W   = 24;
    localparam int TGT_W   = 25;

    // Depth of the queue between the front and back parts (a power of two).
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Character codes.
    localparam logic [7:0] CHR_HASH  = 8'h23;
    localparam logic [7:0] CHR_LOW_A = 8'h61;
    localparam logic [7:0] CHR_UP_A  = 8'h41;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    // Class of one character after the front part has looked at it.
    // CH_DROP marks the end of an overlong line: it clears the parser without a report.
    typedef enum logic [3:0] {
        CH_WS,
        CH_DIGIT,
        CH_HASH,
        CH_ALL,
        CH_MINUS,
        CH_PLUS,
        CH_OTHER,
        CH_EOL,
        CH_DROP
    } t_chr_class;

    // One queued token: class and, for digits, the digit value.
    typedef struct packed {
        t_chr_class  kind;
        logic [3:0]  digit;
    } t_token;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    // Parser phase of the back part.
    typedef enum logic [2:0] {
        PH_HASH,
        PH_SEL,
        PH_GAP,
        PH_SIGN,
        PH_DIGITS
    } t_phase;

    // Status reported at the end of a line.
    typedef enum logic [1:0] {
        ST_SINGLE = 2'd0,
        ST_ALL    = 2'd1,
        ST_REJECT = 2'd2
    } t_line_status;

    typedef logic signed [TGT_W-1:0] t_target;

endpackage

// ===== rtl/wheel_target_command_parser.sv =====
// Wheel target command parser.
// Input channel: one received byte per item on i_rx_byte, taken at a rising
// edge with i_valid high and o_stall low. Lines of the form "#N v" or
// "#a v1 v2 v3 v4" end with CR or LF; spaces and tabs are skipped.
// Output channel: at the end of each non-empty line that did not overflow,
// one item carries the line status, the updated wheel and all four stored
// targets. It is taken at an edge with o_valid high and i_stall low.
// Throughput is one byte per cycle while o_stall is low. A line end is
// classified and written into the token queue at the accepting edge, and
// the parser loads its result register when it pops that token, which
// waits for a free result slot. While the receiver stalls, the result is
// held and the parser keeps consuming characters up to the next line end;
// the four-entry token queue then fills, and o_stall rises only once it is full.
// Reset clears the line state, the queue, the result valid flag and all four
// stored targets to zero.
module wheel_target_command_parser
    import wtcp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_rx_byte,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_line_status,
    output logic [1:0]         o_updated_wheel,
    output logic signed [24:0] o_wheel_target_1,
    output logic signed [24:0] o_wheel_target_2,
    output logic signed [24:0] o_wheel_target_3,
    output logic signed [24:0] o_wheel_target_4
);

    t_queue_stat  qstat;
    t_token       push_token;
    t_token       head_token;
    logic         push;
    logic         pop;
    t_line_status status;
    t_target      targets [WHEELS];

    // Front part: classifies bytes and tracks line length.
    wtcp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .i_qstat   (qstat),
        .o_push    (push),
        .o_token   (push_token)
    );

    // Token queue between the two parts.
    wtcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_token),
        .i_pop   (pop),
        .o_token (head_token),
        .o_qstat (qstat)
    );

    // Back part: parses tokens and commits targets.
    wtcp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qstat         (qstat),
        .i_token         (head_token),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_line_status   (status),
        .o_updated_wheel (o_updated_wheel),
        .o_targets       (targets)
    );

    assign o_line_status    = status;
    assign o_wheel_target_1 = targets[0];
    assign o_wheel_target_2 = targets[1];
    assign o_wheel_target_3 = targets[2];
    assign o_wheel_target_4 = targets[3];

endmodule

// ===== rtl/wtcp_front.sv =====
module wtcp_front
    import wtcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_stall,
    input  t_queue_stat i_qstat,
    output logic        o_push,
    output t_token      o_token
);

    logic             r_null;
    logic             n_null;
    logic             r_ovf;
    logic             n_ovf;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             accept;
    logic             is_eol;
    t_chr_class       cls;

    // The input stalls only while the queue is full.
    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;
    assign is_eol  = (i_rx_byte == CHR_LF) || (i_rx_byte == CHR_CR);

    // Classify the received character.
    always_comb begin
        if (is_eol) begin
            // The end of an overlong line only clears the parser.
            cls = r_ovf ? CH_DROP : CH_EOL;
        end else if (i_rx_byte == CHR_SPACE || i_rx_byte == CHR_TAB) begin
            cls = CH_WS;
        end else if (i_rx_byte >= CHR_ZERO && i_rx_byte <= CHR_NINE) begin
            cls = CH_DIGIT;
        end else if (i_rx_byte == CHR_HASH) begin
            cls = CH_HASH;
        end else if (i_rx_byte == CHR_LOW_A || i_rx_byte == CHR_UP_A) begin
            cls = CH_ALL;
        end else if (i_rx_byte == CHR_MINUS) begin
            cls = CH_MINUS;
        end else if (i_rx_byte == CHR_PLUS) begin
            cls = CH_PLUS;
        end else begin
            cls = CH_OTHER;
        end
    end

    assign o_token.kind  = cls;
    assign o_token.digit = 4'(i_rx_byte - CHR_ZERO);

    // Line length, overflow and zero byte tracking decide which items reach the queue.
    always_comb begin
        n_len  = r_len;
        n_ovf  = r_ovf;
        n_null = r_null;
        o_push = 1'b0;
        if (accept) begin
            if (is_eol) begin
                // An empty line ends without a token; an overlong one sends a drop marker.
                o_push = (r_len != '0);
                n_len  = '0;
                n_ovf  = 1'b0;
                n_null = 1'b0;
            end else if (!r_ovf) begin
                if (r_len < LEN_W'(LINE_MAX - 1)) begin
                    n_len = r_len + 1'b1;
                    if (!r_null) begin
                        if (i_rx_byte == CHR_NUL) begin
                            n_null = 1'b1;
                        end else begin
                            o_push = 1'b1;
                        end
                    end
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_null <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_ovf  <= n_ovf;
            r_null <= n_null;
        end
    end

endmodule

// ===== rtl/wtcp_queue.sv =====
module wtcp_queue
    import wtcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_token      i_token,
    input  logic        i_pop,
    output t_token      o_token,
    output t_queue_stat o_qstat
);

    t_token            r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;

    assign o_qstat.full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_token       = r_slot[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Token slots carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_token;
        end
    end

    // The front never pushes into a full queue and the back never pops an empty one.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qstat.full |-> !i_push)
        else $error("queue written while full");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qstat.empty |-> !i_pop)
        else $error("queue read while empty");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

// ===== rtl/wtcp_back.sv =====
module wtcp_back
    import wtcp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_queue_stat  i_qstat,
    input  t_token       i_token,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_stall,
    output t_line_status o_line_status,
    output logic [1:0]   o_updated_wheel,
    output t_target      o_targets [WHEELS]
);

    t_phase              r_phase;
    t_phase              n_phase;
    logic                r_invalid;
    logic                n_invalid;
    logic                r_neg;
    logic                n_neg;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    logic [DCNT_W-1:0]   r_dcnt;
    logic [DCNT_W-1:0]   n_dcnt;
    logic [VCNT_W-1:0]   r_vcnt;
    logic [VCNT_W-1:0]   n_vcnt;
    logic                r_all;
    logic                n_all;
    logic [WHEEL_W-1:0]  r_wsel;
    logic [WHEEL_W-1:0]  n_wsel;
    t_target             r_pend [WHEELS];
    t_target             n_pend [WHEELS];
    t_target             r_targets [WHEELS];
    t_target             n_targets [WHEELS];
    logic                r_out_valid;
    logic                n_out_valid;
    t_line_status        r_status;
    t_line_status        n_status;
    logic [WHEEL_W-1:0]  r_wheel;
    logic [WHEEL_W-1:0]  n_wheel;

    logic                out_free;
    logic                is_eol;
    logic                is_drop;
    logic                pop_eol;
    logic                pop_drop;
    logic                pop_chr;
    t_target             close_val;
    t_phase              ph;
    logic [VCNT_W-1:0]   vc;
    logic                eff_dig;
    logic                ok;
    logic [VCNT_W-1:0]   eff_vcnt;

    // A line end needs a free result slot; other tokens are taken at once.
    assign out_free = !r_out_valid || !i_stall;
    assign is_eol   = (i_token.kind == CH_EOL);
    assign is_drop  = (i_token.kind == CH_DROP);
    assign o_pop    = !i_qstat.empty && (!is_eol || out_free);
    assign pop_eol  = o_pop && is_eol;
    assign pop_drop = o_pop && is_drop;
    assign pop_chr  = o_pop && !is_eol && !is_drop;

    // The value being closed, with its sign applied.
    assign close_val = r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});

    // Parser step for one token, and the line end commit.
    always_comb begin
        n_phase     = r_phase;
        n_invalid   = r_invalid;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_dcnt      = r_dcnt;
        n_vcnt      = r_vcnt;
        n_all       = r_all;
        n_wsel      = r_wsel;
        n_pend      = r_pend;
        n_targets   = r_targets;
        n_status    = r_status;
        n_wheel     = r_wheel;
        n_out_valid = r_out_valid && i_stall;
        ph          = r_phase;
        vc          = r_vcnt;
        eff_dig     = !r_invalid && (r_phase == PH_DIGITS);
        ok          = !r_invalid && (r_phase == PH_GAP || r_phase == PH_DIGITS);
        eff_vcnt    = r_vcnt + VCNT_W'(eff_dig);

        if (pop_chr && !r_invalid) begin
            if (r_phase == PH_DIGITS && i_token.kind == CH_DIGIT) begin
                // Another digit of the current value.
                if (r_dcnt >= DCNT_W'(MAX_DIGITS)) begin
                    n_invalid = 1'b1;
                end else begin
                    n_acc  = (r_acc << 3) + (r_acc << 1) + ACC_W'(i_token.digit);
                    n_dcnt = r_dcnt + 1'b1;
                end
            end else begin
                // A non-digit closes a value in progress first.
                if (r_phase == PH_DIGITS) begin
                    if (r_vcnt < VCNT_W'(WHEELS)) begin
                        n_pend[r_vcnt[WHEEL_W-1:0]] = close_val;
                    end
                    n_vcnt = r_vcnt + 1'b1;
                    vc     = r_vcnt + 1'b1;
                    n_neg  = 1'b0;
                    n_acc  = '0;
                    n_dcnt = '0;
                    ph     = PH_GAP;
                    n_phase = PH_GAP;
                end
                case (ph)
                    PH_HASH: begin
                        if (i_token.kind == CH_HASH) begin
                            n_phase = PH_SEL;
                        end else if (i_token.kind != CH_WS) begin
                            n_invalid = 1'b1;
                        end
                    end
                    PH_SEL: begin
                        if (i_token.kind == CH_ALL) begin
                            n_all   = 1'b1;
                            n_phase = PH_GAP;
                        end else if (i_token.kind == CH_DIGIT && i_token.digit >= 4'd1
                                     && i_token.digit <= 4'(WHEELS)) begin
                            n_wsel  = WHEEL_W'(i_token.digit - 4'd1);
                            n_phase = PH_GAP;
                        end else if (i_token.kind != CH_WS) begin
                            n_invalid = 1'b1;
                        end
                    end
                    PH_GAP: begin
                        if (i_token.kind != CH_WS) begin
                            if (vc >= VCNT_W'(WHEELS)) begin
                                n_invalid = 1'b1;
                            end else if (i_token.kind == CH_MINUS) begin
                                n_neg   = 1'b1;
                                n_phase = PH_SIGN;
                            end else if (i_token.kind == CH_PLUS) begin
                                n_phase = PH_SIGN;
                            end else if (i_token.kind == CH_DIGIT) begin
                                n_acc   = ACC_W'(i_token.digit);
                                n_dcnt  = DCNT_W'(1);
                                n_phase = PH_DIGITS;
                            end else begin
                                n_invalid = 1'b1;
                            end
                        end
                    end
                    PH_SIGN: begin
                        if (i_token.kind == CH_DIGIT) begin
                            n_acc   = ACC_W'(i_token.digit);
                            n_dcnt  = DCNT_W'(1);
                            n_phase = PH_DIGITS;
                        end else begin
                            n_invalid = 1'b1;
                        end
                    end
                    default: begin
                        n_invalid = 1'b1;
                    end
                endcase
            end
        end

        if (pop_eol) begin
            // Commit the line if it parsed, then report.
            n_status = ST_REJECT;
            n_wheel  = '0;
            if (ok && r_all) begin
                if (eff_vcnt == VCNT_W'(WHEELS)) begin
                    for (int i = 0; i < WHEELS; i++) begin
                        n_targets[i] = (eff_dig && r_vcnt == VCNT_W'(i)) ? close_val
                                                                          : r_pend[i];
                    end
                    n_status = ST_ALL;
                end
            end else if (ok) begin
                if (eff_vcnt == VCNT_W'(1)) begin
                    n_targets[r_wsel] = eff_dig ? close_val : r_pend[0];
                    n_status = ST_SINGLE;
                    n_wheel  = r_wsel;
                end
            end
            n_out_valid = 1'b1;
        end

        if (pop_eol || pop_drop) begin
            // Every line end, reported or dropped, leaves the parser ready for a new line.
            n_phase     = PH_HASH;
            n_invalid   = 1'b0;
            n_neg       = 1'b0;
            n_acc       = '0;
            n_dcnt      = '0;
            n_vcnt      = '0;
            n_all       = 1'b0;
            n_wsel      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HASH;
            r_invalid   <= 1'b0;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_dcnt      <= '0;
            r_vcnt      <= '0;
            r_all       <= 1'b0;
            r_wsel      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WHEELS; i++) begin
                r_targets[i] <= '0;
            end
        end else begin
            r_phase     <= n_phase;
            r_invalid   <= n_invalid;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_dcnt      <= n_dcnt;
            r_vcnt      <= n_vcnt;
            r_all       <= n_all;
            r_wsel      <= n_wsel;
            r_out_valid <= n_out_valid;
            r_targets   <= n_targets;
        end
    end

    // Pending values and the result payload carry no reset.
    always_ff @(posedge i_clk) begin
        r_pend   <= n_pend;
        r_status <= n_status;
        r_wheel  <= n_wheel;
    end

    assign o_valid         = r_out_valid;
    assign o_line_status   = r_status;
    assign o_updated_wheel = 2'(r_wheel);
    assign o_targets       = r_targets;

    // A value in progress always has between one and the maximum number of digits.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIGITS) |-> (r_dcnt != '0 && r_dcnt <= DCNT_W'(MAX_DIGITS)))
        else $error("digit count out of range");
    // No more values are collected than there are wheels.
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= VCNT_W'(WHEELS))
        else $error("value count beyond wheel count");
    // A line end always leaves the parser ready for a new line.
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_eol |=> (r_phase == PH_HASH && r_vcnt == '0 && !r_invalid && r_out_valid))
        else $error("parser not cleared after line end");
    // Only a single wheel update names a wheel.
    a_wheel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_SINGLE) |-> (r_wheel == '0))
        else $error("wheel index set on a non-single result");

endmodule
